### hw/rtl/u2s_pkg.sv
// ----------------------------------------------------------------------------
// u2s_pkg
// Shared types and constants of the UTF-8 to UCS-2 stream decoder.
// ----------------------------------------------------------------------------
package u2s_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [15:0] REPLACEMENT = 16'h003F;
  localparam logic [15:0] MAX_UNIT    = 16'hFFFF;

  localparam logic [2:0] SEQ_LEN_2 = 3'd2;
  localparam logic [2:0] SEQ_LEN_3 = 3'd3;
  localparam logic [2:0] SEQ_LEN_4 = 3'd4;

  // One decoded byte: one or two results.
  typedef struct packed {
    logic        two;
    logic [15:0] unit0;
    logic        bad0;
    logic [15:0] unit1;
    logic        bad1;
  } cmd_t;

endpackage

### hw/rtl/utf8_to_ucs2_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_to_ucs2_stream_decoder_top
// Decodes a UTF-8 byte stream into 16-bit code units.
// ----------------------------------------------------------------------------
// Input side: a byte is transferred on a clock edge with push high and full
// low. Output side: the oldest result sits on code_unit, malformed and
// last_of_run while empty is low, and is transferred on an edge with pop high.
// A byte that completes no sequence yet produces no result; a byte that
// breaks an open sequence may produce two, the second marked last_of_run.
// A byte passes the command queue and the output register before it is shown.
// The input takes one byte every cycle while full is low, the output one
// result every cycle while pop is high, so only two-result bytes make the
// four-entry command queue fill, and full then holds the input off until the
// queue has room again. When the receiver stalls, results wait in the output
// register and the queue, and full rises once the queue is full. Synchronous
// reset empties the queue and output register and drops any open sequence.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_stream_decoder_top
  import u2s_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit,
  output logic        malformed,
  output logic        last_of_run
);

  logic accept;
  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_pop;
  logic cmd_empty;

  assign accept = push && !full;

  u2s_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (in_byte),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  u2s_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .full    (full),
    .empty   (cmd_empty)
  );

  u2s_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_empty   (cmd_empty),
    .cmd         (cmd_out),
    .cmd_pop     (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .code_unit   (code_unit),
    .malformed   (malformed),
    .last_of_run (last_of_run)
  );

endmodule

### hw/rtl/u2s_front.sv
// ----------------------------------------------------------------------------
// u2s_front
// Accepts bytes, tracks the open sequence and emits one command per byte
// that produces results.
// ----------------------------------------------------------------------------
module u2s_front
  import u2s_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  output logic       cmd_push,
  output cmd_t       cmd
);

  logic [1:0] pending_count;
  logic [1:0] pending_count_next;
  logic [2:0] expected_length;
  logic [2:0] expected_length_next;
  logic [7:0] pending_bytes [3];

  logic        is_cont;
  logic [2:0]  held;
  logic        lead_valid;
  logic [15:0] lead_unit;
  logic        lead_bad;
  logic        lead_open;
  logic [2:0]  lead_len;
  logic        done_bad;
  logic [15:0] done_unit;
  logic        wr_lead;
  logic        wr_cont;

  assign is_cont = (in_byte[7:6] == 2'b10);
  assign held    = {1'b0, pending_count} + 3'd1;

  always_comb begin
    lead_valid = 1'b0;
    lead_unit  = REPLACEMENT;
    lead_bad   = 1'b0;
    lead_open  = 1'b0;
    lead_len   = SEQ_LEN_2;
    if (in_byte[7] == 1'b0) begin
      lead_valid = 1'b1;
      lead_unit  = {8'h00, in_byte};
    end else if (in_byte[7:5] == 3'b110) begin
      lead_open = 1'b1;
      lead_len  = SEQ_LEN_2;
    end else if (in_byte[7:4] == 4'b1110) begin
      lead_open = 1'b1;
      lead_len  = SEQ_LEN_3;
    end else if (in_byte[7:3] == 5'b11110) begin
      lead_open = 1'b1;
      lead_len  = SEQ_LEN_4;
    end else begin
      lead_valid = 1'b1;
      lead_bad   = 1'b1;
    end
  end

  always_comb begin
    done_bad  = 1'b0;
    done_unit = '0;
    case (expected_length)
      SEQ_LEN_2: done_unit = {5'd0, pending_bytes[0][4:0], in_byte[5:0]};
      SEQ_LEN_3: done_unit = {pending_bytes[0][3:0], pending_bytes[1][5:0], in_byte[5:0]};
      default: begin
        done_bad  = (pending_bytes[0][2:0] != 3'd0) || (pending_bytes[1][5:4] != 2'd0);
        done_unit = {pending_bytes[1][3:0], pending_bytes[2][5:0], in_byte[5:0]};
      end
    endcase
    if (done_bad || (done_unit > MAX_UNIT)) begin
      done_unit = REPLACEMENT;
    end
  end

  always_comb begin
    cmd                  = '0;
    cmd_push             = 1'b0;
    pending_count_next   = pending_count;
    expected_length_next = expected_length;
    wr_lead              = 1'b0;
    wr_cont              = 1'b0;
    if ((pending_count != 2'd0) && is_cont) begin
      if (held >= expected_length) begin
        cmd.unit0          = done_unit;
        cmd.bad0           = done_bad;
        cmd_push           = accept;
        pending_count_next = 2'd0;
      end else begin
        wr_cont            = accept;
        pending_count_next = held[1:0];
      end
    end else begin
      if (lead_open) begin
        wr_lead              = accept;
        expected_length_next = lead_len;
        pending_count_next   = 2'd1;
      end else begin
        pending_count_next = 2'd0;
      end
      if (pending_count != 2'd0) begin
        cmd.unit0 = REPLACEMENT;
        cmd.bad0  = 1'b1;
        cmd.two   = lead_valid;
        cmd.unit1 = lead_unit;
        cmd.bad1  = lead_bad;
        cmd_push  = accept;
      end else begin
        cmd.unit0 = lead_unit;
        cmd.bad0  = lead_bad;
        cmd_push  = accept && lead_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count   <= 2'd0;
      expected_length <= 3'd0;
    end else if (accept) begin
      pending_count   <= pending_count_next;
      expected_length <= expected_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_lead) begin
      pending_bytes[0] <= in_byte;
    end
    if (wr_cont && (pending_count != 2'd3)) begin
      pending_bytes[pending_count] <= in_byte;
    end
  end

`ifndef SYNTHESIS
  a_open_len: assert property (@(posedge clk) disable iff (rst)
    (pending_count != 2'd0) |-> ({1'b0, pending_count} < expected_length))
    else $error("Open sequence holds more bytes than its length.");

  a_open_range: assert property (@(posedge clk) disable iff (rst)
    (pending_count != 2'd0) |-> (expected_length >= SEQ_LEN_2 && expected_length <= SEQ_LEN_4))
    else $error("Open sequence has an invalid length.");
`endif

endmodule

### hw/rtl/u2s_fifo.sv
// ----------------------------------------------------------------------------
// u2s_fifo
// Short command queue between the front and back parts of the decoder.
// ----------------------------------------------------------------------------
module u2s_fifo
  import u2s_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic full,
  output logic empty
);

  cmd_t                  entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  do_wr;
  logic                  do_rd;

  assign full    = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + FIFO_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("Command queue count exceeds its depth.");
`endif

endmodule

### hw/rtl/u2s_back.sv
// ----------------------------------------------------------------------------
// u2s_back
// Unpacks queued commands into single results behind an output register.
// ----------------------------------------------------------------------------
module u2s_back
  import u2s_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_empty,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit,
  output logic        malformed,
  output logic        last_of_run
);

  logic        out_valid;
  logic        sec_valid;
  logic [15:0] sec_unit;
  logic        sec_bad;
  logic        slot_free;

  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;
  assign cmd_pop   = slot_free && !sec_valid && !cmd_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sec_valid <= 1'b0;
    end else if (slot_free) begin
      if (sec_valid) begin
        out_valid <= 1'b1;
        sec_valid <= 1'b0;
      end else begin
        out_valid <= !cmd_empty;
        sec_valid <= !cmd_empty && cmd.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (sec_valid) begin
        code_unit   <= sec_unit;
        malformed   <= sec_bad;
        last_of_run <= 1'b1;
      end else begin
        code_unit   <= cmd.unit0;
        malformed   <= cmd.bad0;
        last_of_run <= !cmd.two;
        sec_unit    <= cmd.unit1;
        sec_bad     <= cmd.bad1;
      end
    end
  end

`ifndef SYNTHESIS
  a_sec_behind_out: assert property (@(posedge clk) disable iff (rst)
    sec_valid |-> out_valid)
    else $error("Second result held without a first result shown.");

  a_sec_then_last: assert property (@(posedge clk) disable iff (rst)
    (sec_valid && pop) |=> (out_valid && last_of_run))
    else $error("Second result of a byte is not marked as last.");

  a_no_pop_while_sec: assert property (@(posedge clk) disable iff (rst)
    sec_valid |-> !cmd_pop)
    else $error("Command taken while a second result is still held.");
`endif

endmodule

### tb/sv/utf8_to_ucs2_stream_decoder_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_ucs2_stream_decoder_checker
// Watches both queue ports of the decoder, predicts the code units that each
// transferred byte should produce and compares every result transfer, field
// by field, with the oldest predicted unit. Mismatches are counted.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_stream_decoder_checker
  import u2s_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  in_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic [15:0] code_unit,
  input  logic        malformed,
  input  logic        last_of_run,
  output int          errors,
  output int          outstanding
);

  typedef struct packed {
    logic [15:0] code;
    logic        bad;
    logic        tail;
  } decoded_t;

  decoded_t   awaited_units[$];
  logic [1:0] held_cnt;
  logic [2:0] seq_len;
  logic [7:0] held[3];
  int         err_count = 0;

  assign errors = err_count;

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch at %0t on %s: got %0h, expected %0h", $realtime, field, got, want);
    err_count++;
  endtask

  function automatic decoded_t make_unit(input logic [15:0] code, input logic bad);
    decoded_t d;
    d.code = code;
    d.bad  = bad;
    d.tail = 1'b0;
    return d;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    decoded_t   outs[2];
    int         n;
    int         held_next;
    logic [20:0] cp;
    logic       as_lead;
    n = 0;
    as_lead = 1'b1;
    if (held_cnt != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        as_lead = 1'b0;
        held_next = int'(held_cnt) + 1;
        if (held_next >= int'(seq_len)) begin
          case (seq_len)
            SEQ_LEN_2: cp = {10'd0, held[0][4:0], b[5:0]};
            SEQ_LEN_3: cp = {5'd0, held[0][3:0], held[1][5:0], b[5:0]};
            default:   cp = {held[0][2:0], held[1][5:0], held[2][5:0], b[5:0]};
          endcase
          if (cp > {5'd0, MAX_UNIT}) begin
            outs[n] = make_unit(REPLACEMENT, 1'b1);
          end else begin
            outs[n] = make_unit(cp[15:0], 1'b0);
          end
          n++;
          held_cnt = 2'd0;
        end else begin
          held[held_cnt] = b;
          held_cnt = held_next[1:0];
        end
      end else begin
        outs[n] = make_unit(REPLACEMENT, 1'b1);
        n++;
        held_cnt = 2'd0;
      end
    end
    if (as_lead) begin
      if (b[7] == 1'b0) begin
        outs[n] = make_unit({8'd0, b}, 1'b0);
        n++;
      end else if (b[7:5] == 3'b110) begin
        seq_len  = SEQ_LEN_2;
        held[0]  = b;
        held_cnt = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        seq_len  = SEQ_LEN_3;
        held[0]  = b;
        held_cnt = 2'd1;
      end else if (b[7:3] == 5'b11110) begin
        seq_len  = SEQ_LEN_4;
        held[0]  = b;
        held_cnt = 2'd1;
      end else begin
        outs[n] = make_unit(REPLACEMENT, 1'b1);
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      outs[i].tail = (i == n - 1);
      awaited_units.push_back(outs[i]);
    end
  endtask

  task automatic check_result();
    decoded_t want;
    if (awaited_units.size() == 0) begin
      report_mismatch("unexpected code_unit", code_unit, 0);
    end else begin
      want = awaited_units.pop_front();
      if (code_unit !== want.code) report_mismatch("code_unit", code_unit, want.code);
      if (malformed !== want.bad) report_mismatch("malformed", malformed, want.bad);
      if (last_of_run !== want.tail) report_mismatch("last_of_run", last_of_run, want.tail);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      awaited_units.delete();
      held_cnt = 2'd0;
      seq_len  = 3'd0;
      outstanding <= 0;
    end else begin
      if (pop && !empty) check_result();
      if (push && !full) decode_byte(in_byte);
      outstanding <= awaited_units.size();
    end
  end

endmodule

### tb/sv/tb_utf8_to_ucs2_stream_decoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_to_ucs2_stream_decoder_top
// Drives a UTF-8 byte stream into the decoder: a directed set of edge cases,
// then mostly well-formed random sequences mixed with broken sequences and
// stray bytes. Both sides idle at random; a checker module does the scoring.
// ----------------------------------------------------------------------------
module tb_utf8_to_ucs2_stream_decoder_top;

  localparam int RANDOM_BYTES = 1450;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 20;

  logic        clk;
  logic        rst     = 1'b1;
  logic        push    = 1'b0;
  logic [7:0]  in_byte = 8'd0;
  logic        pop     = 1'b0;
  logic        full;
  logic        empty;
  logic [15:0] code_unit;
  logic        malformed;
  logic        last_of_run;
  int          errors;
  int          outstanding;
  int          idle_cycles = 0;
  int          push_burst  = 0;
  int          pop_burst   = 0;
  bit          draining    = 1'b0;

  utf8_to_ucs2_stream_decoder_top dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .in_byte     (in_byte),
    .empty       (empty),
    .pop         (pop),
    .code_unit   (code_unit),
    .malformed   (malformed),
    .last_of_run (last_of_run)
  );

  utf8_to_ucs2_stream_decoder_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .in_byte     (in_byte),
    .empty       (empty),
    .pop         (pop),
    .code_unit   (code_unit),
    .malformed   (malformed),
    .last_of_run (last_of_run),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int next_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) burst = $urandom_range(20, 80);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    bit done;
    gap = next_gap(push_burst);
    if (gap > 0) begin
      push    <= 1'b0;
      in_byte <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    do begin
      @(negedge clk);
      done = !full;
      @(posedge clk);
    end while (!done);
  endtask

  function automatic logic [7:0] lead_of(input int len);
    logic [7:0] r;
    r = 8'($urandom);
    case (len)
      2:       return {3'b110, r[4:0]};
      3:       return {4'b1110, r[3:0]};
      default: return {5'b11110, r[2:0]};
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] r;
    r = 8'($urandom);
    return {2'b10, r[5:0]};
  endfunction

  task automatic send_random_stream();
    int         sent;
    int         r;
    int         len;
    int         k;
    logic [7:0] b;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        send_byte(8'($urandom_range(0, 127)));
        sent++;
      end else if (r < 75) begin
        len = $urandom_range(2, 4);
        if (len == 4 && $urandom_range(0, 3) == 0) begin
          send_byte(8'hF0);
          send_byte({4'b1000, 4'($urandom)});
          k = 2;
        end else begin
          send_byte(lead_of(len));
          k = 1;
        end
        for (int i = k; i < len; i++) send_byte(cont_byte());
        sent += len;
      end else if (r < 90) begin
        len = $urandom_range(2, 4);
        k = $urandom_range(0, len - 2);
        send_byte(lead_of(len));
        for (int i = 0; i < k; i++) send_byte(cont_byte());
        do b = 8'($urandom_range(0, 255)); while (b[7:6] == 2'b10);
        send_byte(b);
        sent += k + 2;
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int  gap;
    bit  done;
    wait (!rst);
    @(posedge clk);
    forever begin
      gap = draining ? 0 : next_gap(pop_burst);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do begin
        @(negedge clk);
        done = !empty;
        @(posedge clk);
      end while (!done);
    end
  end

  initial begin
    logic [7:0] directed[$];
    directed = '{8'h00, 8'h7F, 8'h3F, 8'h80, 8'hFF, 8'hF8,
                 8'hC2, 8'hA9,
                 8'hE2, 8'h82, 8'hAC,
                 8'hF0, 8'h9F, 8'h98, 8'h80,
                 8'hEF, 8'hBF, 8'hBF,
                 8'hC2, 8'h41,
                 8'hE2, 8'h82, 8'hFF,
                 8'hE2, 8'hC3, 8'hA9};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_byte(directed[i]);
    send_random_stream();
    push <= 1'b0;
    draining = 1'b1;
    do @(negedge clk); while (outstanding != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
